// ===== rtl/btlv_pkg.sv =====
// ----------------------------------------------------------------------------
// btlv_pkg
// Types and constants shared by the BER-TLV tag and length header parser.
// ----------------------------------------------------------------------------
package btlv_pkg;

    // Default number of tag bytes allowed after a multi-byte first tag byte
    localparam int TAG_TAIL_BYTES_DEF = 3;

    // Longest long-form length field that is decoded rather than skipped
    localparam logic [6:0] LENGTH_BYTES_MAX = 7'd8;

    // Low five bits all ones in the first tag byte: multi-byte tag
    localparam logic [4:0] TAG_MULTI_MARK = 5'h1F;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ERROR = 2'd1;
    localparam logic [1:0] STATUS_DONE  = 2'd2;

    localparam logic [1:0] CAUSE_NONE      = 2'd0;
    localparam logic [1:0] CAUSE_TRUNCATED = 2'd1;
    localparam logic [1:0] CAUSE_TAG_LONG  = 2'd2;
    localparam logic [1:0] CAUSE_LEN_LONG  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_header;
        logic       end_of_data;
    } btlv_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  error_cause;
        logic [31:0] tag_value;
        logic [63:0] length_value;
        logic [7:0]  header_bytes;
    } btlv_result_t;

endpackage

// ===== rtl/ber_tlv_tag_length_parser.sv =====
// ----------------------------------------------------------------------------
// ber_tlv_tag_length_parser
// Decodes one BER-TLV tag and length from header bytes, one byte per item.
// ----------------------------------------------------------------------------
//  channel  | signals                          | payload
//  ---------+----------------------------------+---------------------------
//  input    | item_valid / item_ready          | item   (btlv_item_t)
//  output   | result_valid / result_ready      | result (btlv_result_t)
//
//  One item per cycle. Each byte updates the parse state in the same cycle
//  it is taken; a header that completes (or end of data) loads the result
//  register, so the result appears in the cycle after its last item.
//  item_ready is low only while a result waits and result_ready is low.
//  rst_n clears the parse state and the result valid flag.
// ----------------------------------------------------------------------------
module ber_tlv_tag_length_parser
#(
    parameter int TAG_TAIL_BYTES = btlv_pkg::TAG_TAIL_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  btlv_pkg::btlv_item_t   item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output btlv_pkg::btlv_result_t result
);
    import btlv_pkg::*;

    localparam int CNT_W = $clog2(TAG_TAIL_BYTES + 1);
    localparam logic [CNT_W-1:0] TAIL_MAX = CNT_W'(TAG_TAIL_BYTES);

    typedef enum logic [2:0] {
        PH_TAG_FIRST,
        PH_TAG_TAIL,
        PH_TAG_SKIP,
        PH_LEN_FIRST,
        PH_LEN_BYTES,
        PH_LEN_SKIP
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [31:0]  tag_reg, tag_next;
    logic [CNT_W-1:0] tag_cnt_reg, tag_cnt_next;
    logic [63:0]  len_reg, len_next;
    logic [6:0]   left_reg, left_next;
    logic [7:0]   count_reg, count_next;
    logic [1:0]   perr_reg, perr_next;

    logic         out_valid_reg;
    btlv_result_t out_reg;

    logic         item_fire;
    logic         emit;
    btlv_result_t res;
    logic [7:0]   b;

    // effective state after an optional restart
    phase_t       ph_e;
    logic [31:0]  tag_e;
    logic [CNT_W-1:0] cnt_e;
    logic [63:0]  len_e;
    logic [6:0]   left_e;
    logic [7:0]   count_e;
    logic [1:0]   perr_e;
    logic [7:0]   count_inc;
    logic [6:0]   left_dec;
    logic [63:0]  len_shift;

    assign item_ready   = !out_valid_reg || result_ready;
    assign item_fire    = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign b            = item.data_byte;

    always_comb
    begin
        if (item.start_header)
        begin
            ph_e    = PH_TAG_FIRST;
            tag_e   = '0;
            cnt_e   = '0;
            len_e   = '0;
            left_e  = '0;
            count_e = '0;
            perr_e  = CAUSE_NONE;
        end
        else
        begin
            ph_e    = phase_reg;
            tag_e   = tag_reg;
            cnt_e   = tag_cnt_reg;
            len_e   = len_reg;
            left_e  = left_reg;
            count_e = count_reg;
            perr_e  = perr_reg;
        end

        count_inc = (count_e == 8'hFF) ? count_e : count_e + 8'd1;
        left_dec  = left_e - 7'd1;
        len_shift = {len_e[55:0], b};

        phase_next   = ph_e;
        tag_next     = tag_e;
        tag_cnt_next = cnt_e;
        len_next     = len_e;
        left_next    = left_e;
        count_next   = count_e;
        perr_next    = perr_e;

        emit             = 1'b0;
        res.status       = (perr_e != CAUSE_NONE) ? STATUS_ERROR : STATUS_OK;
        res.error_cause  = perr_e;
        res.tag_value    = (perr_e == CAUSE_TAG_LONG) ? 32'd0 : tag_e;
        res.length_value = len_e;
        res.header_bytes = count_inc;

        if (item.end_of_data)
        begin
            emit = 1'b1;
            if (ph_e == PH_TAG_FIRST)
            begin
                res.status       = STATUS_DONE;
                res.error_cause  = CAUSE_NONE;
                res.tag_value    = '0;
                res.length_value = '0;
                res.header_bytes = '0;
            end
            else
            begin
                res.status       = STATUS_ERROR;
                res.error_cause  = CAUSE_TRUNCATED;
                res.length_value = '0;
                res.header_bytes = count_e;
            end
        end
        else
        begin
            count_next = count_inc;
            case (ph_e)
                PH_TAG_FIRST:
                begin
                    tag_next     = {24'd0, b};
                    tag_cnt_next = '0;
                    phase_next   = (b[4:0] == TAG_MULTI_MARK) ? PH_TAG_TAIL : PH_LEN_FIRST;
                end
                PH_TAG_TAIL:
                begin
                    if (cnt_e < TAIL_MAX)
                    begin
                        tag_next     = {tag_e[23:0], b};
                        tag_cnt_next = cnt_e + CNT_W'(1);
                    end
                    else
                    begin
                        perr_next  = CAUSE_TAG_LONG;
                        tag_next   = '0;
                        phase_next = PH_TAG_SKIP;
                    end
                    if (!b[7])
                    begin
                        phase_next = PH_LEN_FIRST;
                    end
                end
                PH_TAG_SKIP:
                begin
                    if (!b[7])
                    begin
                        phase_next = PH_LEN_FIRST;
                    end
                end
                PH_LEN_FIRST:
                begin
                    if (!b[7])
                    begin
                        emit             = 1'b1;
                        res.length_value = {56'd0, b};
                    end
                    else if (b[6:0] == 7'd0)
                    begin
                        emit             = 1'b1;
                        res.length_value = '0;
                    end
                    else if (b[6:0] > LENGTH_BYTES_MAX)
                    begin
                        left_next  = b[6:0];
                        len_next   = '1;
                        phase_next = PH_LEN_SKIP;
                        if (perr_e == CAUSE_NONE)
                        begin
                            perr_next = CAUSE_LEN_LONG;
                        end
                    end
                    else
                    begin
                        left_next  = b[6:0];
                        len_next   = '0;
                        phase_next = PH_LEN_BYTES;
                    end
                end
                PH_LEN_BYTES:
                begin
                    len_next  = len_shift;
                    left_next = left_dec;
                    if (left_dec == 7'd0)
                    begin
                        emit             = 1'b1;
                        res.length_value = len_shift;
                    end
                end
                PH_LEN_SKIP:
                begin
                    left_next = left_dec;
                    if (left_dec == 7'd0)
                    begin
                        emit = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_TAG_FIRST;
                    tag_next   = '0;
                    len_next   = '0;
                    left_next  = '0;
                    count_next = '0;
                    perr_next  = CAUSE_NONE;
                    tag_cnt_next = '0;
                end
            endcase
        end

        // a result or end of data closes the header
        if (emit)
        begin
            phase_next   = PH_TAG_FIRST;
            tag_next     = '0;
            tag_cnt_next = '0;
            len_next     = '0;
            left_next    = '0;
            count_next   = '0;
            perr_next    = CAUSE_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TAG_FIRST;
            tag_reg       <= '0;
            tag_cnt_reg   <= '0;
            len_reg       <= '0;
            left_reg      <= '0;
            count_reg     <= '0;
            perr_reg      <= CAUSE_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_fire)
            begin
                phase_reg   <= phase_next;
                tag_reg     <= tag_next;
                tag_cnt_reg <= tag_cnt_next;
                len_reg     <= len_next;
                left_reg    <= left_next;
                count_reg   <= count_next;
                perr_reg    <= perr_next;
            end
            if (item_fire && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire && emit)
        begin
            out_reg <= res;
        end
    end

    // end of data always yields a result next cycle
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item.end_of_data |=> out_valid_reg)
        else $error("end of data without result");

    a_done_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == STATUS_DONE |->
        out_reg.tag_value == '0 && out_reg.length_value == '0
        && out_reg.header_bytes == '0 && out_reg.error_cause == CAUSE_NONE)
        else $error("done result carries data");

    a_status_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
        ((out_reg.status == STATUS_ERROR) == (out_reg.error_cause != CAUSE_NONE)))
        else $error("status and cause disagree");

    a_tag_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tag_cnt_reg <= TAIL_MAX)
        else $error("tag byte count out of range");

    a_tag_long_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.error_cause == CAUSE_TAG_LONG |->
        out_reg.tag_value == '0)
        else $error("long tag reported nonzero");

endmodule

// ===== tb/tb_ber_tlv_tag_length_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ber_tlv_tag_length_parser
// Self-checking bench for the BER-TLV tag and length header parser. Header
// bytes are sent in random bursts while the result side stalls on its own
// schedule. A short directed table comes first, then well-formed headers
// with random content mixed with truncated, restarted and noise items. Each
// accepted item runs through a local decoder, and every result is compared
// field by field against it, or against the table entry for checked rows.
// ----------------------------------------------------------------------------
module tb_ber_tlv_tag_length_parser;

    import btlv_pkg::*;

    localparam int RANDOM_ITEMS  = 850;
    localparam int LONG_TAG_TAIL = 270;   // pushes the byte count past saturation

    typedef enum logic [2:0] {
        EXPECT_TAG,
        IN_TAG_TAIL,
        SKIP_TAG,
        EXPECT_LEN,
        IN_LEN_BYTES,
        SKIP_LEN
    } hdr_phase_t;

    typedef struct {
        btlv_item_t   it;
        bit           fixed;
        btlv_result_t want;
    } dir_row_t;

    logic         clk;
    logic         rst_n        = 1'b0;
    logic         item_valid   = 1'b0;
    logic         item_ready;
    btlv_item_t   item         = '0;
    logic         result_valid;
    logic         result_ready = 1'b0;
    btlv_result_t result;

    // local decoder state
    hdr_phase_t   hdr_phase;
    logic [31:0]  tag_acc;
    int           tail_seen;
    logic [63:0]  len_acc;
    logic [6:0]   len_left;
    logic [7:0]   hdr_count;
    logic [1:0]   hdr_cause;

    btlv_result_t header_results_q[$];
    dir_row_t     dir_rows[$];
    btlv_item_t   stim_q[$];
    logic [7:0]   hdr_bytes[$];
    bit           force_start;
    int           burst_left;
    int           mismatches;
    int           stall_mode;
    int           stall_left;

    ber_tlv_tag_length_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("ber_tlv_tag_length_parser: mismatch");
        $finish;
    end

    function automatic void clear_header();
        hdr_phase = EXPECT_TAG;
        tag_acc   = '0;
        tail_seen = 0;
        len_acc   = '0;
        len_left  = '0;
        hdr_count = '0;
        hdr_cause = CAUSE_NONE;
    endfunction

    // Returns 1 when this byte closes a header or the data ends.
    function automatic bit decode_header_byte(input btlv_item_t it, output btlv_result_t res);
        logic [7:0] b;
        bit         done;
        b    = it.data_byte;
        res  = '0;
        done = 1'b0;
        if (it.start_header)
            clear_header();
        if (it.end_of_data)
        begin
            if (hdr_phase == EXPECT_TAG)
                res.status = STATUS_DONE;
            else
            begin
                res.status       = STATUS_ERROR;
                res.error_cause  = CAUSE_TRUNCATED;
                res.tag_value    = (hdr_cause == CAUSE_TAG_LONG) ? '0 : tag_acc;
                res.header_bytes = hdr_count;
                clear_header();
            end
            return 1'b1;
        end
        if (hdr_count != 8'hFF)
            hdr_count++;
        case (hdr_phase)
            EXPECT_TAG:
            begin
                tag_acc   = {24'h0, b};
                tail_seen = 0;
                hdr_phase = (b[4:0] == TAG_MULTI_MARK) ? IN_TAG_TAIL : EXPECT_LEN;
            end
            IN_TAG_TAIL:
            begin
                if (tail_seen < TAG_TAIL_BYTES_DEF)
                begin
                    tag_acc = {tag_acc[23:0], b};
                    tail_seen++;
                end
                else
                begin
                    hdr_cause = CAUSE_TAG_LONG;
                    tag_acc   = '0;
                    hdr_phase = SKIP_TAG;
                end
                if (!b[7])
                    hdr_phase = EXPECT_LEN;
            end
            SKIP_TAG:
                if (!b[7])
                    hdr_phase = EXPECT_LEN;
            EXPECT_LEN:
            begin
                len_acc = '0;
                if (!b[7])
                begin
                    len_acc = {56'h0, b};
                    done    = 1'b1;
                end
                else
                begin
                    len_left = b[6:0];
                    if (len_left == 7'd0)
                        done = 1'b1;
                    else if (len_left > LENGTH_BYTES_MAX)
                    begin
                        len_acc = '1;
                        if (hdr_cause == CAUSE_NONE)
                            hdr_cause = CAUSE_LEN_LONG;
                        hdr_phase = SKIP_LEN;
                    end
                    else
                        hdr_phase = IN_LEN_BYTES;
                end
            end
            IN_LEN_BYTES:
            begin
                len_acc = {len_acc[55:0], b};
                len_left--;
                done = (len_left == 7'd0);
            end
            SKIP_LEN:
            begin
                len_left--;
                done = (len_left == 7'd0);
            end
            default:
                clear_header();
        endcase
        if (done)
        begin
            res.status       = (hdr_cause != CAUSE_NONE) ? STATUS_ERROR : STATUS_OK;
            res.error_cause  = hdr_cause;
            res.tag_value    = (hdr_cause == CAUSE_TAG_LONG) ? '0 : tag_acc;
            res.length_value = len_acc;
            res.header_bytes = hdr_count;
            clear_header();
        end
        return done;
    endfunction

    function automatic void add_row(logic [7:0] d, bit s, bit e);
        dir_row_t r;
        r.it    = '{data_byte: d, start_header: s, end_of_data: e};
        r.fixed = 1'b0;
        r.want  = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_checked_row(logic [7:0] d, bit s, bit e, logic [1:0] st,
                                            logic [1:0] ca, logic [31:0] tag,
                                            logic [63:0] len, logic [7:0] cnt);
        dir_row_t r;
        r.it    = '{data_byte: d, start_header: s, end_of_data: e};
        r.fixed = 1'b1;
        r.want  = '{status: st, error_cause: ca, tag_value: tag, length_value: len,
                    header_bytes: cnt};
        dir_rows.push_back(r);
    endfunction

    // Builds one header into hdr_bytes; tail_n of 0 gives a single-byte tag.
    function automatic void build_header(int tail_n);
        logic [7:0] b;
        int         sel;
        int         n_len;
        hdr_bytes.delete();
        b = 8'($urandom);
        if (tail_n == 0)
        begin
            if (b[4:0] == TAG_MULTI_MARK)
                b[0] = 1'b0;
            hdr_bytes.push_back(b);
        end
        else
        begin
            b[4:0] = TAG_MULTI_MARK;
            hdr_bytes.push_back(b);
            for (int i = 1; i <= tail_n; i++)
            begin
                b    = 8'($urandom);
                b[7] = (i != tail_n);
                hdr_bytes.push_back(b);
            end
        end
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            b    = 8'($urandom);
            b[7] = 1'b0;
            hdr_bytes.push_back(b);
        end
        else
        begin
            if (sel == 3)
                n_len = 0;
            else if (sel == 9)
                n_len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 127)
                                                     : $urandom_range(9, 12);
            else
                n_len = $urandom_range(1, 8);
            hdr_bytes.push_back({1'b1, 7'(n_len)});
            for (int i = 0; i < n_len; i++)
            begin
                case ($urandom_range(0, 3))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom);
                endcase
                hdr_bytes.push_back(b);
            end
        end
    endfunction

    function automatic void queue_header(int n);
        bit s;
        s = force_start || ($urandom_range(0, 3) == 0);
        force_start = 1'b0;
        for (int i = 0; i < n; i++)
            stim_q.push_back('{data_byte: hdr_bytes[i], start_header: (i == 0) && s,
                               end_of_data: 1'b0});
    endfunction

    function automatic void build_random_items();
        int sel;
        bit long_done;
        long_done = 1'b0;
        while (stim_q.size() < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (!long_done && stim_q.size() > RANDOM_ITEMS / 2)
            begin
                build_header(LONG_TAG_TAIL);
                queue_header(hdr_bytes.size());
                long_done = 1'b1;
            end
            else if (sel < 75)
            begin
                build_header(($urandom_range(0, 2) == 0) ? 0
                             : $urandom_range(1, TAG_TAIL_BYTES_DEF + 2));
                queue_header(hdr_bytes.size());
            end
            else if (sel < 87)
            begin
                // header cut short, then end of data or a restart
                build_header(($urandom_range(0, 2) == 0) ? 0
                             : $urandom_range(1, TAG_TAIL_BYTES_DEF + 2));
                queue_header($urandom_range(1, hdr_bytes.size() - 1));
                if ($urandom_range(0, 1) == 0)
                    stim_q.push_back('{data_byte: 8'($urandom),
                                       start_header: 1'($urandom_range(0, 1)),
                                       end_of_data: 1'b1});
                else
                    force_start = 1'b1;
            end
            else if (sel < 95)
                stim_q.push_back('{data_byte: 8'($urandom),
                                   start_header: ($urandom_range(0, 2) == 0),
                                   end_of_data: ($urandom_range(0, 7) == 0)});
            else
                stim_q.push_back('{data_byte: 8'($urandom), start_header: 1'b0,
                                   end_of_data: 1'b1});
        end
    endfunction

    task automatic send_item(input btlv_item_t it, input bit fixed, input btlv_result_t want);
        btlv_result_t res;
        bit           got;
        int           gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        got = decode_header_byte(it, res);
        if (fixed)
            header_results_q.push_back(want);
        else if (got)
            header_results_q.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 50)
            $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // receiver: modes of always ready, coin flip, long stalls and a fixed rhythm
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 64);
        end
        stall_left--;
        case (stall_mode)
            0:       result_ready <= 1'b1;
            1:       result_ready <= ($urandom_range(0, 1) == 0);
            2:       result_ready <= ($urandom_range(0, 7) == 0);
            default: result_ready <= (stall_left % 3) != 0;
        endcase
    end

    always @(posedge clk)
    begin
        btlv_result_t e;
        if (rst_n && result_valid && result_ready)
        begin
            if (header_results_q.size() == 0)
                report_mismatch("result with nothing expected", result.length_value, '0);
            else
            begin
                e = header_results_q.pop_front();
                if (result.status !== e.status)
                    report_mismatch("status", 64'(result.status), 64'(e.status));
                if (result.error_cause !== e.error_cause)
                    report_mismatch("error_cause", 64'(result.error_cause),
                                    64'(e.error_cause));
                if (result.tag_value !== e.tag_value)
                    report_mismatch("tag_value", 64'(result.tag_value), 64'(e.tag_value));
                if (result.length_value !== e.length_value)
                    report_mismatch("length_value", result.length_value, e.length_value);
                if (result.header_bytes !== e.header_bytes)
                    report_mismatch("header_bytes", 64'(result.header_bytes),
                                    64'(e.header_bytes));
            end
        end
    end

    initial
    begin
        mismatches  = 0;
        burst_left  = 0;
        force_start = 1'b0;
        stall_mode  = 0;
        stall_left  = 0;
        clear_header();

        // end of data right after reset
        add_checked_row(8'h00, 1'b0, 1'b1, STATUS_DONE, CAUSE_NONE, '0, '0, 8'd0);
        // smallest header
        add_row(8'h00, 1'b1, 1'b0);
        add_checked_row(8'h00, 1'b0, 1'b0, STATUS_OK, CAUSE_NONE, '0, '0, 8'd2);
        // longest allowed tag, zero length count
        add_row(8'h1F, 1'b0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0);
        add_row(8'h7F, 1'b0, 1'b0);
        add_checked_row(8'h80, 1'b0, 1'b0, STATUS_OK, CAUSE_NONE, 32'h1FFF_FF7F, '0, 8'd5);
        // tag two bytes too long
        add_row(8'h3F, 1'b0, 1'b0);
        add_row(8'h81, 1'b0, 1'b0);
        add_row(8'h82, 1'b0, 1'b0);
        add_row(8'h83, 1'b0, 1'b0);
        add_row(8'h84, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0);
        add_checked_row(8'h7F, 1'b0, 1'b0, STATUS_ERROR, CAUSE_TAG_LONG, '0, 64'h7F, 8'd7);
        // oversized length count cut by end of data: truncation wins
        add_row(8'h5F, 1'b0, 1'b0);
        add_row(8'h10, 1'b0, 1'b0);
        add_row(8'h89, 1'b0, 1'b0);
        add_checked_row(8'hA5, 1'b0, 1'b1, STATUS_ERROR, CAUSE_TRUNCATED, 32'h5F10, '0, 8'd3);
        // restart mid header, then a length with a trailing zero byte
        add_row(8'h02, 1'b1, 1'b0);
        add_row(8'h1F, 1'b1, 1'b0);
        add_row(8'h01, 1'b0, 1'b0);
        add_row(8'h82, 1'b0, 1'b0);
        add_row(8'h01, 1'b0, 1'b0);
        add_checked_row(8'h00, 1'b0, 1'b0, STATUS_OK, CAUSE_NONE, 32'h1F01, 64'h100, 8'd5);
        // restart together with end of data
        add_checked_row(8'hFF, 1'b1, 1'b1, STATUS_DONE, CAUSE_NONE, '0, '0, 8'd0);

        build_random_items();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].want);
        foreach (stim_q[i])
            send_item(stim_q[i], 1'b0, '0);
        item_valid <= 1'b0;

        while (header_results_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("ber_tlv_tag_length_parser: match");
        else
            $display("ber_tlv_tag_length_parser: mismatch");
        $finish;
    end

endmodule
